/* rtl/core/ptfe_pkg.sv */
package ptfe_pkg;

  localparam int MAX_CHANNELS_DEF = 8;
  localparam int SAMPLE_W         = 16;
  localparam int FRAMES_W         = 31;
  localparam int POS_W            = 32;
  localparam int CHCNT_W          = 4;
  localparam int REG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 31;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ENABLE    = 3'd0,
    REG_FOREVER   = 3'd1,
    REG_CHANNELS  = 3'd2,
    REG_TRIM      = 3'd3,
    REG_LEAD_PAD  = 3'd4,
    REG_BODY      = 3'd5,
    REG_FADE      = 3'd6,
    REG_PAD_END   = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    CMD_PASS,
    CMD_SILENT,
    CMD_END,
    CMD_TRIM,
    CMD_FADE
  } cmd_kind_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    cmd_kind_e                  kind;
    logic [FRAMES_W-1:0]        remain;
    logic [FRAMES_W-1:0]        fade;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } bk_state_e;

endpackage

/* rtl/core/ptfe_front.sv */
module ptfe_front
  import ptfe_pkg::*;
#(
  parameter int MaxChannels = MAX_CHANNELS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [REG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                       push_i,
  input  logic signed [SAMPLE_W-1:0] in_sample_i,
  input  logic                       q_full_i,
  output logic                       full_o,
  output logic                       cmd_we_o,
  output cmd_t                       cmd_o
);

  localparam int CH_W = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int NW   = CH_W + 1;

  logic                enable_q, forever_q;
  logic [CHCNT_W-1:0]  chcnt_q;
  logic [FRAMES_W-1:0] padb_q, body_q, fade_q, pade_q, trim_rem_q;
  logic [POS_W-1:0]    fs_q;
  logic [POS_W:0]      pes_q, pl_q;
  logic [1:0]          settle_q, settle_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [CH_W-1:0]     ch_q, ch_d;
  logic [FRAMES_W-1:0] trim_rem_d;

  logic [NW-1:0] n_eff;
  logic          ch_last, adv_ch, adv_pos, dec_trim, accept;
  logic [POS_W:0] p_ext, remain_full;

  assign full_o   = q_full_i || (settle_q != 2'd0);
  assign accept   = push_i && !full_o;
  assign cmd_we_o = accept;

  always_comb begin
    if (chcnt_q == '0) begin
      n_eff = NW'(1);
    end else if (int'(chcnt_q) > MaxChannels) begin
      n_eff = NW'(MaxChannels);
    end else begin
      n_eff = NW'(chcnt_q);
    end
  end

  // a stale index past a shrunk count counts as the last channel
  assign ch_last     = ({1'b0, ch_q} + NW'(1)) >= n_eff;
  assign p_ext       = {1'b0, pos_q};
  assign remain_full = pes_q - p_ext;

  always_comb begin
    cmd_o.sample = in_sample_i;
    cmd_o.kind   = CMD_PASS;
    cmd_o.remain = remain_full[FRAMES_W-1:0];
    cmd_o.fade   = fade_q;
    adv_ch       = 1'b0;
    adv_pos      = 1'b0;
    dec_trim     = 1'b0;
    if (!enable_q) begin
      adv_ch = 1'b1;
    end else if (trim_rem_q != '0) begin
      cmd_o.kind = CMD_TRIM;
      adv_ch     = 1'b1;
      dec_trim   = ch_last;
    end else if (!forever_q && p_ext >= pl_q) begin
      cmd_o.kind = CMD_END;
    end else if (pos_q < {1'b0, padb_q}) begin
      cmd_o.kind = CMD_SILENT;
      adv_ch     = 1'b1;
      adv_pos    = 1'b1;
    end else if (!forever_q && p_ext >= pes_q) begin
      cmd_o.kind = CMD_SILENT;
      adv_ch     = 1'b1;
      adv_pos    = 1'b1;
    end else if (!forever_q && fade_q != '0 && pos_q >= fs_q) begin
      cmd_o.kind = CMD_FADE;
      adv_ch     = 1'b1;
      adv_pos    = 1'b1;
    end else begin
      adv_ch  = 1'b1;
      adv_pos = 1'b1;
    end
  end

  always_comb begin
    ch_d       = ch_q;
    pos_d      = pos_q;
    trim_rem_d = trim_rem_q;
    if (accept) begin
      if (adv_ch) begin
        ch_d = ch_last ? '0 : ch_q + CH_W'(1);
      end
      // hold the position once it saturates
      if (adv_pos && ch_last && pos_q != '1) begin
        pos_d = pos_q + POS_W'(1);
      end
      if (dec_trim) begin
        trim_rem_d = trim_rem_q - FRAMES_W'(1);
      end
    end
    if (cfg_we_i && reg_idx_e'(cfg_idx_i) == REG_TRIM) begin
      trim_rem_d = cfg_wdata_i[FRAMES_W-1:0];
    end
  end

  // hold input off while the region bounds ripple through their adders
  assign settle_d = cfg_we_i ? 2'd3 : ((settle_q != 2'd0) ? settle_q - 2'd1 : settle_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      forever_q  <= 1'b0;
      chcnt_q    <= CHCNT_W'(2);
      padb_q     <= '0;
      body_q     <= '0;
      fade_q     <= '0;
      pade_q     <= '0;
      fs_q       <= '0;
      pes_q      <= '0;
      pl_q       <= '0;
      settle_q   <= 2'd0;
      pos_q      <= '0;
      ch_q       <= '0;
      trim_rem_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_ENABLE:    enable_q  <= cfg_wdata_i[0];
          REG_FOREVER:   forever_q <= cfg_wdata_i[0];
          REG_CHANNELS:  chcnt_q   <= cfg_wdata_i[CHCNT_W-1:0];
          REG_TRIM:      ;
          REG_LEAD_PAD:  padb_q    <= cfg_wdata_i[FRAMES_W-1:0];
          REG_BODY:      body_q    <= cfg_wdata_i[FRAMES_W-1:0];
          REG_FADE:      fade_q    <= cfg_wdata_i[FRAMES_W-1:0];
          REG_PAD_END:   pade_q    <= cfg_wdata_i[FRAMES_W-1:0];
          default:       ;
        endcase
      end
      fs_q       <= {1'b0, padb_q} + {1'b0, body_q};
      pes_q      <= {1'b0, fs_q} + {2'b0, fade_q};
      pl_q       <= pes_q + {2'b0, pade_q};
      settle_q   <= settle_d;
      pos_q      <= pos_d;
      ch_q       <= ch_d;
      trim_rem_q <= trim_rem_d;
    end
  end

endmodule

/* rtl/core/ptfe_cmdq.sv */
module ptfe_cmdq
  import ptfe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  cmd_t wr_data_i,
  input  logic rd_en_i,
  output logic full_o,
  output logic avail_o,
  output cmd_t rd_data_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o    = cnt_q == 2'd2;
  assign avail_o   = cnt_q != 2'd0;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd_en_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({wr_en_i, rd_en_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* rtl/core/ptfe_back.sv */
module ptfe_back
  import ptfe_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_avail_i,
  input  cmd_t                       cmd_i,
  output logic                       cmd_rd_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic signed [SAMPLE_W-1:0] out_sample_o,
  output logic                       out_valid_o,
  output logic                       sample_taken_o,
  output logic                       play_end_o
);

  localparam int PROD_W = SAMPLE_W + FRAMES_W;
  localparam logic [3:0] DIV_LAST = 4'(SAMPLE_W - 1);

  bk_state_e state_q, state_d;

  logic [SAMPLE_W-1:0] mag_q, low_q;
  logic                neg_q;
  logic [FRAMES_W-1:0] remain_q, fade_q, rem_q;
  logic [3:0]          cnt_q;

  logic                vld_q;
  logic [SAMPLE_W-1:0] osample_q;
  logic                ovalid_q, otaken_q, oend_q;

  logic                out_free, out_load;
  logic [SAMPLE_W-1:0] raw, mag, res_sample, load_sample;
  logic                load_valid, load_taken, load_end;
  logic [PROD_W-1:0]   prod;
  logic [FRAMES_W:0]   trial, trial_diff;
  logic                ge;

  assign out_free = !vld_q || pop_i;
  assign raw      = cmd_i.sample;
  assign mag      = raw[SAMPLE_W-1] ? (~raw + SAMPLE_W'(1)) : raw;
  assign prod     = PROD_W'(mag_q) * PROD_W'(remain_q);

  // one quotient bit per cycle; the quotient never exceeds the sample magnitude
  assign trial      = {rem_q, low_q[SAMPLE_W-1]};
  assign ge         = trial >= {1'b0, fade_q};
  assign trial_diff = trial - {1'b0, fade_q};
  assign res_sample = neg_q ? (~low_q + SAMPLE_W'(1)) : low_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_avail_i && out_free && cmd_i.kind == CMD_FADE) begin
          state_d = BK_MUL;
        end
      end
      BK_MUL:  state_d = BK_DIV;
      BK_DIV: begin
        if (cnt_q == DIV_LAST) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_rd_o    = (state_q == BK_IDLE) && cmd_avail_i && out_free;
    out_load    = (cmd_rd_o && cmd_i.kind != CMD_FADE) || (state_q == BK_DONE && out_free);
    load_sample = '0;
    load_valid  = 1'b0;
    load_taken  = 1'b0;
    load_end    = 1'b0;
    if (state_q == BK_DONE) begin
      load_sample = res_sample;
      load_valid  = 1'b1;
      load_taken  = 1'b1;
    end else begin
      case (cmd_i.kind)
        CMD_PASS: begin
          load_sample = raw;
          load_valid  = 1'b1;
          load_taken  = 1'b1;
        end
        CMD_SILENT: load_valid = 1'b1;
        CMD_END:    load_end   = 1'b1;
        CMD_TRIM:   load_taken = 1'b1;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_rd_o) begin
      mag_q    <= mag;
      neg_q    <= raw[SAMPLE_W-1];
      remain_q <= cmd_i.remain;
      fade_q   <= cmd_i.fade;
    end
    case (state_q)
      BK_MUL: begin
        rem_q <= prod[PROD_W-1:SAMPLE_W];
        low_q <= prod[SAMPLE_W-1:0];
        cnt_q <= '0;
      end
      BK_DIV: begin
        rem_q <= ge ? trial_diff[FRAMES_W-1:0] : trial[FRAMES_W-1:0];
        low_q <= {low_q[SAMPLE_W-2:0], ge};
        cnt_q <= cnt_q + 4'd1;
      end
      default: ;
    endcase
    if (out_load) begin
      osample_q <= load_sample;
      ovalid_q  <= load_valid;
      otaken_q  <= load_taken;
      oend_q    <= load_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        vld_q <= 1'b1;
      end else if (pop_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  assign empty_o        = !vld_q;
  assign out_sample_o   = osample_q;
  assign out_valid_o    = ovalid_q;
  assign sample_taken_o = otaken_q;
  assign play_end_o     = oend_q;

endmodule

/* rtl/core/playback_trim_pad_fade_envelope.sv */
// A pass, silence, trim or end item passes through the command queue and the output register.
// A fade item goes through a multiply state, a serial divide state and a done state.
// Throughput: one item per cycle while the output is free; a fade item holds back the next.
// After any configuration write, full stays high while region bounds settle.
// Reset (rst_ni low, asynchronous) resets position, channel, trim count, queues and config.
module playback_trim_pad_fade_envelope
  import ptfe_pkg::*;
#(
  parameter int MaxChannels = MAX_CHANNELS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [REG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] in_sample_i,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [SAMPLE_W-1:0] out_sample_o,
  output logic                       out_valid_o,
  output logic                       sample_taken_o,
  output logic                       play_end_o
);

  cmd_t front_cmd, back_cmd;
  logic cmd_we, cmd_rd, q_full, q_avail;

  ptfe_front #(
    .MaxChannels(MaxChannels)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .in_sample_i (in_sample_i),
    .q_full_i    (q_full),
    .full_o      (full),
    .cmd_we_o    (cmd_we),
    .cmd_o       (front_cmd)
  );

  ptfe_cmdq u_cmdq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_we),
    .wr_data_i (front_cmd),
    .rd_en_i   (cmd_rd),
    .full_o    (q_full),
    .avail_o   (q_avail),
    .rd_data_o (back_cmd)
  );

  ptfe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_avail_i    (q_avail),
    .cmd_i          (back_cmd),
    .cmd_rd_o       (cmd_rd),
    .pop_i          (pop),
    .empty_o        (empty),
    .out_sample_o   (out_sample_o),
    .out_valid_o    (out_valid_o),
    .sample_taken_o (sample_taken_o),
    .play_end_o     (play_end_o)
  );

  a_end_not_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(out_valid_o && play_end_o))
    else $error("result flags both valid and end of play");

  a_end_not_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && play_end_o) |-> !sample_taken_o)
    else $error("end of play consumed a sample");

  a_invalid_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_valid_o) |-> (out_sample_o == '0))
    else $error("non-valid result carries a nonzero sample");

  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> full)
    else $error("input open right after a configuration write");

endmodule
